// ===== hdl/hlp_pkg.sv =====
// Shared types, codes and character constants for the hex load file parser.
// Used by every module of the block; depends on nothing.
package hlp_pkg;

  localparam int ADDR_WIDTH_DEF     = 32;
  localparam int MAX_ADDR_BYTES_DEF = 4;
  localparam int OUT_ADDR_WIDTH     = 32;
  localparam int MIN_ADDR_BYTES     = 2;

  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_DATA_LO = 3'd1;
  localparam logic [2:0] PH_CMD     = 3'd2;
  localparam logic [2:0] PH_ADDR_HI = 3'd3;
  localparam logic [2:0] PH_ADDR_LO = 3'd4;
  localparam logic [2:0] PH_HALT    = 3'd5;

  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_END   = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  localparam logic [2:0] ERR_NO_DATA  = 3'd0;
  localparam logic [2:0] ERR_ILLEGAL  = 3'd1;
  localparam logic [2:0] ERR_UNK_CMD  = 3'd2;
  localparam logic [2:0] ERR_SHORT    = 3'd3;
  localparam logic [2:0] ERR_COMMA    = 3'd4;
  localparam logic [2:0] ERR_HEX      = 3'd5;
  localparam logic [2:0] ERR_NONE     = 3'd0;

  localparam logic [7:0] CHAR_SPACE  = 8'h20;
  localparam logic [7:0] CHAR_TAB    = 8'h09;
  localparam logic [7:0] CHAR_CR     = 8'h0D;
  localparam logic [7:0] CHAR_LF     = 8'h0A;
  localparam logic [7:0] CHAR_FF     = 8'h0C;
  localparam logic [7:0] CHAR_CTRL_Z = 8'h1A;
  localparam logic [7:0] CHAR_DOLLAR = 8'h24;
  localparam logic [7:0] CHAR_CMD_A  = 8'h41;
  localparam logic [7:0] CHAR_COMMA  = 8'h2C;
  localparam logic [7:0] CHAR_0      = 8'h30;
  localparam logic [7:0] CHAR_9      = 8'h39;
  localparam logic [7:0] CHAR_LC_A   = 8'h61;
  localparam logic [7:0] CHAR_LC_F   = 8'h66;
  localparam logic [7:0] CHAR_UC_A   = 8'h41;
  localparam logic [7:0] CHAR_UC_F   = 8'h46;

  typedef struct packed {
    logic       is_hex;
    logic [3:0] hex_val;
    logic       is_space;
    logic       is_dollar;
    logic       is_cmd_a;
    logic       is_comma;
  } char_class_t;

  typedef struct packed {
    logic [1:0]                event_kind;
    logic [7:0]                data_byte;
    logic [OUT_ADDR_WIDTH-1:0] byte_address;
    logic [2:0]                error_code;
  } result_t;

endpackage

// ===== hdl/hex_load_file_char_parser_unit.sv =====
// Top level: one character beat per cycle while in_ready is high, at most one result beat per character.
// Each result is registered in the output buffer before it appears on the output.
// The two-entry output buffer keeps input open
// for one more beat while a result is stalled, and closes it while both entries are full.
// Reset (synchronous, active high) returns the parser to idle with address zero and
// empties the output buffer. Depends on hlp_pkg, hlp_char_class, hlp_parse_core, hlp_out_buffer.
module hex_load_file_char_parser_unit #(
  parameter int ADDR_WIDTH     = hlp_pkg::ADDR_WIDTH_DEF,
  parameter int MAX_ADDR_BYTES = hlp_pkg::MAX_ADDR_BYTES_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [7:0]                          char_code,
  input  logic                                end_of_input,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [1:0]                          event_kind,
  output logic [7:0]                          data_byte,
  output logic [hlp_pkg::OUT_ADDR_WIDTH-1:0]  byte_address,
  output logic [2:0]                          error_code
);
  import hlp_pkg::*;

  char_class_t cls;
  logic        accept;
  logic        res_valid;
  result_t     res;
  result_t     out_data;

  assign accept = in_valid && in_ready;

  hlp_char_class u_class (
    .char_code    (char_code),
    .end_of_input (end_of_input),
    .cls          (cls)
  );

  hlp_parse_core #(
    .ADDR_WIDTH     (ADDR_WIDTH),
    .MAX_ADDR_BYTES (MAX_ADDR_BYTES)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .end_of_input (end_of_input),
    .cls          (cls),
    .res_valid    (res_valid),
    .res          (res)
  );

  hlp_out_buffer u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (accept && res_valid),
    .push_data (res),
    .ready     (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign event_kind   = out_data.event_kind;
  assign data_byte    = out_data.data_byte;
  assign byte_address = out_data.byte_address;
  assign error_code   = out_data.error_code;

endmodule

// ===== hdl/hlp_char_class.sv =====
// Character classifier: hex digit value and the special characters of the format.
// Depends on hlp_pkg.
module hlp_char_class (
  input  logic                 [7:0] char_code,
  input  logic                       end_of_input,
  output hlp_pkg::char_class_t       cls
);
  import hlp_pkg::*;

  logic is_digit;
  logic is_lower;
  logic is_upper;
  logic [7:0] offset;

  always_comb begin
    is_digit = (char_code >= CHAR_0) && (char_code <= CHAR_9);
    is_lower = (char_code >= CHAR_LC_A) && (char_code <= CHAR_LC_F);
    is_upper = (char_code >= CHAR_UC_A) && (char_code <= CHAR_UC_F);
    if (is_digit) begin
      offset = char_code - CHAR_0;
    end else if (is_lower) begin
      offset = char_code - CHAR_LC_A + 8'd10;
    end else begin
      offset = char_code - CHAR_UC_A + 8'd10;
    end
    cls.is_hex    = !end_of_input && (is_digit || is_lower || is_upper);
    cls.hex_val   = offset[3:0];
    cls.is_space  = !end_of_input && ((char_code == CHAR_SPACE) || (char_code == CHAR_TAB) ||
                    (char_code == CHAR_CR) || (char_code == CHAR_LF) ||
                    (char_code == CHAR_FF) || (char_code == CHAR_CTRL_Z));
    cls.is_dollar = !end_of_input && (char_code == CHAR_DOLLAR);
    cls.is_cmd_a  = !end_of_input && (char_code == CHAR_CMD_A);
    cls.is_comma  = !end_of_input && (char_code == CHAR_COMMA);
  end

endmodule

// ===== hdl/hlp_parse_core.sv =====
// Parser state registers and the combinational next-state and result logic.
// Depends on hlp_pkg; consumes the classifier output.
module hlp_parse_core #(
  parameter int ADDR_WIDTH     = hlp_pkg::ADDR_WIDTH_DEF,
  parameter int MAX_ADDR_BYTES = hlp_pkg::MAX_ADDR_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  logic                 end_of_input,
  input  hlp_pkg::char_class_t cls,
  output logic                 res_valid,
  output hlp_pkg::result_t     res
);
  import hlp_pkg::*;

  localparam int CountWidth = $clog2(MAX_ADDR_BYTES + 1);

  logic [2:0]            phase;
  logic [2:0]            phase_next;
  logic [3:0]            pending_nibble;
  logic [3:0]            pending_nibble_next;
  logic [ADDR_WIDTH-1:0] load_address;
  logic [ADDR_WIDTH-1:0] load_address_next;
  logic [CountWidth-1:0] address_byte_count;
  logic [CountWidth-1:0] address_byte_count_next;
  logic                  saw_data;
  logic                  saw_data_next;
  logic [7:0]            pair_byte;
  logic [63:0]           addr_wide;

  assign pair_byte = {pending_nibble, cls.hex_val};
  assign addr_wide = 64'(load_address);

  always_comb begin
    phase_next              = phase;
    pending_nibble_next     = pending_nibble;
    load_address_next       = load_address;
    address_byte_count_next = address_byte_count;
    saw_data_next           = saw_data;
    res_valid               = 1'b0;
    res.event_kind          = KIND_DATA;
    res.data_byte           = 8'd0;
    res.byte_address        = '0;
    res.error_code          = ERR_NONE;
    unique case (phase)
      PH_IDLE: begin
        if (end_of_input) begin
          res_valid = 1'b1;
          if (!saw_data) begin
            res.event_kind = KIND_ERROR;
            res.error_code = ERR_NO_DATA;
            phase_next     = PH_HALT;
          end else begin
            res.event_kind = KIND_END;
          end
        end else if (cls.is_hex) begin
          pending_nibble_next = cls.hex_val;
          phase_next          = PH_DATA_LO;
        end else if (cls.is_space) begin
          phase_next = PH_IDLE;
        end else if (cls.is_dollar) begin
          phase_next = PH_CMD;
        end else begin
          res_valid      = 1'b1;
          res.event_kind = KIND_ERROR;
          res.error_code = ERR_ILLEGAL;
          phase_next     = PH_HALT;
        end
      end
      PH_DATA_LO: begin
        res_valid = 1'b1;
        if (!cls.is_hex) begin
          res.event_kind = KIND_ERROR;
          res.error_code = ERR_HEX;
          phase_next     = PH_HALT;
        end else begin
          res.data_byte       = pair_byte;
          res.byte_address    = addr_wide[OUT_ADDR_WIDTH-1:0];
          pending_nibble_next = 4'd0;
          saw_data_next       = 1'b1;
          load_address_next   = load_address + ADDR_WIDTH'(1);
          phase_next          = PH_IDLE;
        end
      end
      PH_CMD: begin
        if (!cls.is_cmd_a) begin
          res_valid      = 1'b1;
          res.event_kind = KIND_ERROR;
          res.error_code = ERR_UNK_CMD;
          phase_next     = PH_HALT;
        end else begin
          load_address_next       = '0;
          address_byte_count_next = '0;
          phase_next              = PH_ADDR_HI;
        end
      end
      PH_ADDR_HI: begin
        if (address_byte_count >= CountWidth'(MAX_ADDR_BYTES)) begin
          if (!cls.is_comma) begin
            res_valid      = 1'b1;
            res.event_kind = KIND_ERROR;
            res.error_code = ERR_COMMA;
            phase_next     = PH_HALT;
          end else begin
            phase_next = PH_IDLE;
          end
        end else if (cls.is_comma) begin
          if (address_byte_count < CountWidth'(MIN_ADDR_BYTES)) begin
            res_valid      = 1'b1;
            res.event_kind = KIND_ERROR;
            res.error_code = ERR_SHORT;
            phase_next     = PH_HALT;
          end else begin
            phase_next = PH_IDLE;
          end
        end else if (!cls.is_hex) begin
          res_valid      = 1'b1;
          res.event_kind = KIND_ERROR;
          res.error_code = ERR_HEX;
          phase_next     = PH_HALT;
        end else begin
          pending_nibble_next = cls.hex_val;
          phase_next          = PH_ADDR_LO;
        end
      end
      PH_ADDR_LO: begin
        if (!cls.is_hex) begin
          res_valid      = 1'b1;
          res.event_kind = KIND_ERROR;
          res.error_code = ERR_HEX;
          phase_next     = PH_HALT;
        end else begin
          load_address_next       = {load_address[ADDR_WIDTH-9:0], pair_byte};
          pending_nibble_next     = 4'd0;
          address_byte_count_next = address_byte_count + CountWidth'(1);
          phase_next              = PH_ADDR_HI;
        end
      end
      default: begin
        phase_next = phase;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= PH_IDLE;
      pending_nibble     <= 4'd0;
      load_address       <= '0;
      address_byte_count <= '0;
      saw_data           <= 1'b0;
    end else if (accept) begin
      phase              <= phase_next;
      pending_nibble     <= pending_nibble_next;
      load_address       <= load_address_next;
      address_byte_count <= address_byte_count_next;
      saw_data           <= saw_data_next;
    end
  end

  a_halt_sticks: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_HALT) |=> (phase == PH_HALT))
    else $error("Parser left the halted phase without reset.");

  a_error_halts: assert property (@(posedge clk) disable iff (rst)
    (accept && res_valid && (res.event_kind == KIND_ERROR)) |=> (phase == PH_HALT))
    else $error("A fatal event did not halt the parser.");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (address_byte_count <= CountWidth'(MAX_ADDR_BYTES)))
    else $error("Address pair count ran past its limit.");

  a_saw_data_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(saw_data) |-> $past(accept && res_valid && (res.event_kind == KIND_DATA)))
    else $error("Data flag set without a data beat.");

endmodule

// ===== hdl/hlp_out_buffer.sv =====
// Two-entry output buffer: a result register plus a skid register.
// Depends on hlp_pkg; lets the parser take a beat while a result is stalled.
module hlp_out_buffer (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  hlp_pkg::result_t push_data,
  output logic             ready,
  output logic             out_valid,
  input  logic             out_ready,
  output hlp_pkg::result_t out_data
);
  import hlp_pkg::*;

  logic    main_valid;
  logic    skid_valid;
  result_t main_data;
  result_t skid_data;

  assign ready     = !skid_valid;
  assign out_valid = main_valid;
  assign out_data  = main_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!main_valid || out_ready) begin
      if (skid_valid) begin
        main_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        main_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!main_valid || out_ready) begin
      main_data <= skid_valid ? skid_data : push_data;
    end else if (push) begin
      skid_data <= push_data;
    end
  end

  a_skid_implies_main: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> main_valid)
    else $error("Skid entry held while the result register is empty.");

  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && out_ready) |=> (main_valid && !skid_valid))
    else $error("Skid entry did not move into the result register.");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> !push)
    else $error("Result pushed while both entries were occupied.");

endmodule

// ===== tb/hex_load_file_char_parser_unit_tb.sv =====
// Self-checking testbench for hex_load_file_char_parser_unit: character beats in, event beats out.
// A cycle-free model predicts events, typed rows aside; depends only on hlp_pkg and the block.
module hex_load_file_char_parser_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hlp_pkg::*;

  localparam int ADDR_W      = ADDR_WIDTH_DEF;
  localparam int MAX_PAIRS   = MAX_ADDR_BYTES_DEF;
  localparam int STALL_LIMIT = 2000;
  localparam int LONG_HOLD   = 80;
  localparam int N_DIRECTED  = 24;

  typedef struct {
    logic [7:0]                ch;
    logic                      eoi;
    bit                        typed;
    logic [1:0]                kind;
    logic [7:0]                dbyte;
    logic [OUT_ADDR_WIDTH-1:0] addr;
    logic [2:0]                code;
  } char_row_t;

  typedef enum {
    TAIL_ILLEGAL, TAIL_UNK_CMD, TAIL_SHORT, TAIL_COMMA,
    TAIL_HEX_DATA, TAIL_HEX_ADDR_HI, TAIL_HEX_ADDR_LO
  } tail_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [7:0]                char_code = 8'h00;
  logic                      end_of_input = 1'b0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [1:0]                event_kind;
  logic [7:0]                data_byte;
  logic [OUT_ADDR_WIDTH-1:0] byte_address;
  logic [2:0]                error_code;

  logic [2:0]        phase = PH_IDLE;
  logic [3:0]        nibble = 4'h0;
  logic [ADDR_W-1:0] run_addr = '0;
  int                pairs = 0;
  bit                seen_data = 1'b0;

  result_t results_due[$];
  int      fail_count = 0;
  int      chars_sent = 0;
  bit      no_gaps = 1'b0;
  bit      long_hold_req = 1'b0;

  char_row_t directed_rows [N_DIRECTED] = '{
    '{CHAR_0,      1'b0, 1'b0, KIND_DATA, 8'h00, 32'h0000_0000, ERR_NONE},
    '{CHAR_0,      1'b0, 1'b1, KIND_DATA, 8'h00, 32'h0000_0000, ERR_NONE},
    '{CHAR_UC_F,   1'b0, 1'b0, KIND_DATA, 8'h00, 32'h0000_0000, ERR_NONE},
    '{CHAR_LC_F,   1'b0, 1'b1, KIND_DATA, 8'hFF, 32'h0000_0001, ERR_NONE},
    '{CHAR_SPACE,  1'b0, 1'b0, KIND_DATA, 8'h00, 32'h0000_0000, ERR_NONE},
    '{CHAR_CTRL_Z, 1'b0, 1'b0, KIND_DATA, 8'h00, 32'h0000_0000, ERR_NONE},
    '{CHAR_TAB,    1'b0, 1'b0, KIND_DATA, 8'h00, 32'h0000_0000, ERR_NONE},
    '{CHAR_DOLLAR, 1'b0, 1'b0, KIND_DATA, 8'h00, 32'h0000_0000, ERR_NONE},
    '{CHAR_CMD_A,  1'b0, 1'b0, KIND_DATA, 8'h00, 32'h0000_0000, ERR_NONE},
    '{CHAR_UC_F,   1'b0, 1'b0, KIND_DATA, 8'h00, 32'h0000_0000, ERR_NONE},
    '{CHAR_LC_F,   1'b0, 1'b0, KIND_DATA, 8'h00, 32'h0000_0000, ERR_NONE},
    '{CHAR_UC_F,   1'b0, 1'b0, KIND_DATA, 8'h00, 32'h0000_0000, ERR_NONE},
    '{CHAR_LC_F,   1'b0, 1'b0, KIND_DATA, 8'h00, 32'h0000_0000, ERR_NONE},
    '{CHAR_UC_F,   1'b0, 1'b0, KIND_DATA, 8'h00, 32'h0000_0000, ERR_NONE},
    '{CHAR_LC_F,   1'b0, 1'b0, KIND_DATA, 8'h00, 32'h0000_0000, ERR_NONE},
    '{CHAR_UC_F,   1'b0, 1'b0, KIND_DATA, 8'h00, 32'h0000_0000, ERR_NONE},
    '{CHAR_LC_F,   1'b0, 1'b0, KIND_DATA, 8'h00, 32'h0000_0000, ERR_NONE},
    '{CHAR_COMMA,  1'b0, 1'b0, KIND_DATA, 8'h00, 32'h0000_0000, ERR_NONE},
    '{CHAR_9,      1'b0, 1'b0, KIND_DATA, 8'h00, 32'h0000_0000, ERR_NONE},
    '{CHAR_LC_A,   1'b0, 1'b1, KIND_DATA, 8'h9A, 32'hFFFF_FFFF, ERR_NONE},
    '{CHAR_0,      1'b0, 1'b0, KIND_DATA, 8'h00, 32'h0000_0000, ERR_NONE},
    '{CHAR_0 + 8'd1, 1'b0, 1'b1, KIND_DATA, 8'h01, 32'h0000_0000, ERR_NONE},
    '{CHAR_COMMA,  1'b1, 1'b1, KIND_END,  8'h00, 32'h0000_0000, ERR_NONE},
    '{CHAR_DOLLAR, 1'b1, 1'b1, KIND_END,  8'h00, 32'h0000_0000, ERR_NONE}
  };

  hex_load_file_char_parser_unit i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .char_code    (char_code),
    .end_of_input (end_of_input),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .event_kind   (event_kind),
    .data_byte    (data_byte),
    .byte_address (byte_address),
    .error_code   (error_code)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit hex_digit(input logic [7:0] ch, output logic [3:0] digit);
    digit = 4'h0;
    if (ch >= CHAR_0 && ch <= CHAR_9) begin
      digit = 4'(ch - CHAR_0);
      return 1'b1;
    end
    if (ch >= CHAR_LC_A && ch <= CHAR_LC_F) begin
      digit = 4'(ch - CHAR_LC_A + 8'd10);
      return 1'b1;
    end
    if (ch >= CHAR_UC_A && ch <= CHAR_UC_F) begin
      digit = 4'(ch - CHAR_UC_A + 8'd10);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic bit is_blank(input logic [7:0] ch);
    return ch == CHAR_SPACE || ch == CHAR_TAB || ch == CHAR_CR || ch == CHAR_LF ||
           ch == CHAR_FF || ch == CHAR_CTRL_Z;
  endfunction

  // Advances the parser state by one character and returns 1 when it yields an event.
  function automatic bit parse_char(input logic [7:0] ch, input logic eoi, output result_t res);
    logic [3:0] digit;
    bit         is_digit;
    bit         bad;
    bit         produced;
    logic [2:0] code;
    is_digit = !eoi && hex_digit(ch, digit);
    res = '0;
    bad = 1'b0;
    produced = 1'b0;
    code = ERR_NONE;
    case (phase)
      PH_IDLE: begin
        if (eoi) begin
          if (seen_data) begin
            res.event_kind = KIND_END;
            produced = 1'b1;
          end else begin
            bad = 1'b1;
            code = ERR_NO_DATA;
          end
        end else if (is_digit) begin
          nibble = digit;
          phase = PH_DATA_LO;
        end else if (ch == CHAR_DOLLAR) begin
          phase = PH_CMD;
        end else if (!is_blank(ch)) begin
          bad = 1'b1;
          code = ERR_ILLEGAL;
        end
      end
      PH_DATA_LO: begin
        if (!is_digit) begin
          bad = 1'b1;
          code = ERR_HEX;
        end else begin
          res.event_kind = KIND_DATA;
          res.data_byte = {nibble, digit};
          res.byte_address = run_addr[OUT_ADDR_WIDTH-1:0];
          run_addr = run_addr + ADDR_W'(1);
          nibble = 4'h0;
          seen_data = 1'b1;
          phase = PH_IDLE;
          produced = 1'b1;
        end
      end
      PH_CMD: begin
        if (eoi || ch != CHAR_CMD_A) begin
          bad = 1'b1;
          code = ERR_UNK_CMD;
        end else begin
          run_addr = '0;
          pairs = 0;
          phase = PH_ADDR_HI;
        end
      end
      PH_ADDR_HI: begin
        if (pairs >= MAX_PAIRS) begin
          if (eoi || ch != CHAR_COMMA) begin
            bad = 1'b1;
            code = ERR_COMMA;
          end else begin
            phase = PH_IDLE;
          end
        end else if (!eoi && ch == CHAR_COMMA) begin
          if (pairs < MIN_ADDR_BYTES) begin
            bad = 1'b1;
            code = ERR_SHORT;
          end else begin
            phase = PH_IDLE;
          end
        end else if (!is_digit) begin
          bad = 1'b1;
          code = ERR_HEX;
        end else begin
          nibble = digit;
          phase = PH_ADDR_LO;
        end
      end
      PH_ADDR_LO: begin
        if (!is_digit) begin
          bad = 1'b1;
          code = ERR_HEX;
        end else begin
          run_addr = {run_addr[ADDR_W-9:0], nibble, digit};
          nibble = 4'h0;
          pairs++;
          phase = PH_ADDR_HI;
        end
      end
      default: ;
    endcase
    if (bad) begin
      phase = PH_HALT;
      res.event_kind = KIND_ERROR;
      res.error_code = code;
      produced = 1'b1;
    end
    return produced;
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] digit);
    if (digit < 4'd10) return CHAR_0 + 8'(digit);
    return ($urandom_range(0, 1) ? CHAR_LC_A : CHAR_UC_A) + 8'(digit - 4'd10);
  endfunction

  function automatic logic [7:0] junk_char();
    logic [7:0] ch;
    logic [3:0] ignored_digit;
    do
      ch = 8'($urandom_range(0, 255));
    while (hex_digit(ch, ignored_digit) || is_blank(ch) || ch == CHAR_DOLLAR ||
           ch == CHAR_COMMA);
    return ch;
  endfunction

  function automatic logic [7:0] blank_char();
    logic [7:0] blanks [6];
    blanks = '{CHAR_SPACE, CHAR_TAB, CHAR_CR, CHAR_LF, CHAR_FF, CHAR_CTRL_Z};
    return blanks[$urandom_range(0, 5)];
  endfunction

  task automatic flag(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    fail_count++;
  endtask

  // Called at a rising edge; returns at the rising edge where the beat is taken.
  task automatic send_char(input logic [7:0] ch, input logic eoi);
    int gap;
    bit took;
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    char_code <= ch;
    end_of_input <= eoi;
    do begin
      @(negedge clk);
      took = in_valid && in_ready;
      @(posedge clk);
    end while (!took);
    chars_sent++;
  endtask

  task automatic feed(input logic [7:0] ch, input logic eoi);
    result_t res;
    if (parse_char(ch, eoi, res)) results_due.push_back(res);
    send_char(ch, eoi);
  endtask

  task automatic feed_byte(input logic [7:0] b);
    feed(hex_char(b[7:4]), 1'b0);
    feed(hex_char(b[3:0]), 1'b0);
  endtask

  task automatic feed_non_hex();
    int pick;
    pick = $urandom_range(0, 2);
    if (pick == 0) feed(blank_char(), 1'b0);
    else if (pick == 1) feed(8'($urandom_range(0, 255)), 1'b1);
    else feed(junk_char(), 1'b0);
  endtask

  task automatic feed_addr_prefix(input int n);
    feed(CHAR_DOLLAR, 1'b0);
    feed(CHAR_CMD_A, 1'b0);
    repeat (n) feed_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (results_due.size() != 0);
  endtask

  always @(negedge clk) begin : catch_results
    result_t want;
    if (!rst && out_valid === 1'b1 && out_ready) begin
      if (results_due.size() == 0) begin
        flag($sformatf("unexpected event kind %0d", event_kind));
      end else begin
        want = results_due.pop_front();
        if (event_kind !== want.event_kind)
          flag($sformatf("event_kind %0d, want %0d", event_kind, want.event_kind));
        if (data_byte !== want.data_byte)
          flag($sformatf("data_byte %h, want %h", data_byte, want.data_byte));
        if (byte_address !== want.byte_address)
          flag($sformatf("byte_address %h, want %h", byte_address, want.byte_address));
        if (error_code !== want.error_code)
          flag($sformatf("error_code %0d, want %0d", error_code, want.error_code));
      end
    end
  end

  initial begin : sink
    int n;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      n = pick_gap();
      if (n > 0) begin
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(0, 19)) @(posedge clk);
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(negedge clk);
      if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin : stimulus
    result_t res;
    result_t typed_res;
    int      roll;
    int      n;
    bit      burst_done;
    bit      pause_done;
    tail_t   tail;
    burst_done = 1'b0;
    pause_done = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      if (parse_char(directed_rows[i].ch, directed_rows[i].eoi, res)) begin
        typed_res.event_kind = directed_rows[i].kind;
        typed_res.data_byte = directed_rows[i].dbyte;
        typed_res.byte_address = directed_rows[i].addr;
        typed_res.error_code = directed_rows[i].code;
        results_due.push_back(directed_rows[i].typed ? typed_res : res);
      end
      send_char(directed_rows[i].ch, directed_rows[i].eoi);
    end

    while (chars_sent < 500) begin
      if (!burst_done && chars_sent >= 200) begin
        // The sink stalls while data beats keep coming, so the output buffer fills.
        burst_done = 1'b1;
        no_gaps = 1'b1;
        long_hold_req = 1'b1;
        repeat (40) feed_byte(8'($urandom_range(0, 255)));
        no_gaps = 1'b0;
      end else if (!pause_done && chars_sent >= 350) begin
        pause_done = 1'b1;
        drain();
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
          n = $urandom_range(0, 9);
          feed_byte(n == 0 ? 8'h00 : n == 1 ? 8'hFF : 8'($urandom_range(0, 255)));
        end else if (roll < 70) begin
          feed(blank_char(), 1'b0);
        end else if (roll < 90) begin
          n = $urandom_range(MIN_ADDR_BYTES, MAX_PAIRS);
          feed(CHAR_DOLLAR, 1'b0);
          feed(CHAR_CMD_A, 1'b0);
          roll = $urandom_range(0, 9);
          repeat (n) feed_byte(roll == 0 ? 8'hFF : roll == 1 ? 8'h00 :
                               8'($urandom_range(0, 255)));
          feed(CHAR_COMMA, 1'b0);
        end else begin
          feed(8'($urandom_range(0, 255)), 1'b1);
        end
      end
    end

    // The parser halts on its first error, so the run ends with one broken sequence.
    tail = tail_t'($urandom_range(0, 6));
    case (tail)
      TAIL_ILLEGAL: feed(junk_char(), 1'b0);
      TAIL_UNK_CMD: begin
        feed(CHAR_DOLLAR, 1'b0);
        feed_non_hex();
      end
      TAIL_SHORT: begin
        feed_addr_prefix($urandom_range(0, MIN_ADDR_BYTES - 1));
        feed(CHAR_COMMA, 1'b0);
      end
      TAIL_COMMA: begin
        feed_addr_prefix(MAX_PAIRS);
        if ($urandom_range(0, 3) == 0) feed(hex_char(4'($urandom_range(0, 15))), 1'b0);
        else feed_non_hex();
      end
      TAIL_HEX_DATA: begin
        feed(hex_char(4'($urandom_range(0, 15))), 1'b0);
        feed_non_hex();
      end
      TAIL_HEX_ADDR_HI: begin
        feed_addr_prefix($urandom_range(0, MAX_PAIRS - 1));
        feed_non_hex();
      end
      default: begin
        feed_addr_prefix($urandom_range(0, MAX_PAIRS - 1));
        feed(hex_char(4'($urandom_range(0, 15))), 1'b0);
        feed_non_hex();
      end
    endcase
    repeat (20) feed(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));

    drain();
    repeat (20) @(posedge clk);
    if (fail_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
